>>> hw/rtl/triangle_tangent_basis_core_assert.svh
// Assertion macros shared by the tangent basis block.
`ifndef TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH

// Clocked assertion, checking suspended while reset is applied.
`define TTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication form: when ante holds, cons must hold in the same cycle.
`define TTB_ASSERT_IMPL(lbl, ante, cons, msg) \
    `TTB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/ttb_pkg.sv
// Types, widths and status codes of the triangle tangent basis block.
package ttb_pkg;

    localparam int POS_W   = 32;
    localparam int UV_W    = 16;
    localparam int OUT_W   = 16;
    localparam int E_W     = POS_W + 1;
    localparam int D_W     = UV_W + 1;
    localparam int P_W     = E_W + D_W;
    localparam int V_W     = P_W + 1;
    localparam int TB_W    = $clog2(V_W);
    localparam int TOP_BIT = 29;
    localparam int S_W     = TOP_BIT + 1;
    localparam int SUM_W   = 64;
    localparam int L_W     = 32;
    localparam int QB      = OUT_W - 1;
    localparam int N_W     = S_W + OUT_W - 1;
    localparam int Q_DEPTH = 2;
    localparam int UNIT    = 1 << (OUT_W - 2);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DET_ZERO = 2'd1;
    localparam logic [1:0] STATUS_LEN_ZERO = 2'd2;

    typedef logic signed [E_W-1:0] edge_t;
    typedef logic signed [D_W-1:0] duv_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [UV_W-1:0]  tex_u;
        logic signed [UV_W-1:0]  tex_v;
    } corner_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] binormal_x;
        logic signed [OUT_W-1:0] binormal_y;
        logic signed [OUT_W-1:0] binormal_z;
        logic [1:0]              status;
    } result_t;

    typedef struct packed {
        edge_t [2:0] e1;
        edge_t [2:0] e2;
        duv_t        du1;
        duv_t        dv1;
        duv_t        du2;
        duv_t        dv2;
    } job_t;

endpackage

>>> hw/rtl/ttb_queue.sv
// Two-entry job queue between the corner front end and the math back end.
module ttb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ttb_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output ttb_pkg::job_t rd_data,
    output logic          rd_valid
);
    import ttb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    job_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ttb_front.sv
// Corner collector: keeps two corners and forms edge and UV deltas on the third.
module ttb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ttb_pkg::corner_t corner,
    output logic             full,
    output logic             job_push,
    output ttb_pkg::job_t    job,
    input  logic             queue_full
);
    import ttb_pkg::*;

    corner_t    kept_reg [2];
    logic [1:0] count_reg;
    logic       accept;
    logic       third;

    assign third    = (count_reg == 2'd2);
    assign full     = third && queue_full;
    assign accept   = push && !full;
    assign job_push = accept && third;

    always_comb
    begin
        job.e1[0] = E_W'(kept_reg[1].pos_x) - E_W'(kept_reg[0].pos_x);
        job.e1[1] = E_W'(kept_reg[1].pos_y) - E_W'(kept_reg[0].pos_y);
        job.e1[2] = E_W'(kept_reg[1].pos_z) - E_W'(kept_reg[0].pos_z);
        job.e2[0] = E_W'(corner.pos_x) - E_W'(kept_reg[0].pos_x);
        job.e2[1] = E_W'(corner.pos_y) - E_W'(kept_reg[0].pos_y);
        job.e2[2] = E_W'(corner.pos_z) - E_W'(kept_reg[0].pos_z);
        job.du1   = D_W'(kept_reg[1].tex_u) - D_W'(kept_reg[0].tex_u);
        job.dv1   = D_W'(kept_reg[1].tex_v) - D_W'(kept_reg[0].tex_v);
        job.du2   = D_W'(corner.tex_u) - D_W'(kept_reg[0].tex_u);
        job.dv2   = D_W'(corner.tex_v) - D_W'(kept_reg[0].tex_v);
    end

    always_ff @(posedge clk)
    begin
        if (accept && !third)
        begin
            kept_reg[count_reg[0]] <= corner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= third ? 2'd0 : count_reg + 2'd1;
        end
    end

endmodule

>>> hw/rtl/ttb_back.sv
// Math sequencer: determinant, tangent and binormal, then normalization.
module ttb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  ttb_pkg::job_t    job,
    output logic             job_take,
    output ttb_pkg::result_t res,
    output logic             res_valid,
    input  logic             res_pop
);
    import ttb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_SQ    = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_DIVLD = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                  state_reg;
    job_t                    job_reg;
    logic [4:0]              cnt_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [P_W-1:0]   acc_reg;
    logic signed [V_W-1:0]   det_reg;
    logic signed [V_W-1:0]   vec_reg [6];
    logic                    vsel_reg;
    logic [S_W-1:0]          s_reg [3];
    logic [2:0]              neg_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sq_n_reg;
    logic [SUM_W-1:0]        sq_res_reg;
    logic [SUM_W-1:0]        sq_bit_reg;
    logic [L_W-1:0]          len_reg;
    logic [1:0]              comp_reg;
    logic [L_W-1:0]          rem_reg;
    logic [QB-1:0]           lo_reg;
    logic [QB-1:0]           quo_reg;
    logic signed [OUT_W-1:0] out_reg [6];
    logic [1:0]              status_reg;
    result_t                 res_reg;
    logic                    res_valid_reg;

    logic signed [E_W-1:0]   mul_a;
    logic signed [D_W-1:0]   mul_b;
    logic [2:0]              pair;
    logic [2:0]              prev_pair;
    logic signed [V_W-1:0]   diff;
    logic [V_W-1:0]          mag [3];
    logic [V_W-1:0]          mag_or;
    logic [TB_W-1:0]         top;
    logic [V_W-1:0]          sh_tmp [3];
    logic [S_W-1:0]          s_new [3];
    logic [2:0]              vbase;
    logic [2*S_W-1:0]        sq_prod;
    logic [SUM_W-1:0]        sq_trial;
    logic [N_W-1:0]          num;
    logic [L_W:0]            r2;
    logic                    ge;
    logic [QB-1:0]           q_fin;
    logic signed [OUT_W-1:0] q_val;

    assign job_take  = (state_reg == ST_IDLE) && job_valid;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    assign pair      = cnt_reg[3:1];
    assign prev_pair = 3'(cnt_reg - 5'd1 >> 1);
    assign diff      = V_W'(acc_reg) - V_W'(prod_reg);
    assign vbase     = vsel_reg ? 3'd3 : 3'd0;

    // Operand schedule: pair 0 is the determinant, 1..3 tangent, 4..6 binormal.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (pair) inside
            3'd0:
            begin
                mul_a = cnt_reg[0] ? E_W'(job_reg.du2) : E_W'(job_reg.du1);
                mul_b = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2;
            end
            3'd1, 3'd2, 3'd3:
            begin
                mul_a = cnt_reg[0] ? job_reg.e2[2'(pair - 3'd1)] : job_reg.e1[2'(pair - 3'd1)];
                mul_b = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2;
            end
            3'd4, 3'd5, 3'd6:
            begin
                mul_a = cnt_reg[0] ? job_reg.e1[2'(pair - 3'd4)] : job_reg.e2[2'(pair - 3'd4)];
                mul_b = cnt_reg[0] ? job_reg.du2 : job_reg.du1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Magnitudes, common leading bit and alignment of the current vector.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = vec_reg[vbase + 3'(i)][V_W-1] ? V_W'(-vec_reg[vbase + 3'(i)])
                                                     : V_W'(vec_reg[vbase + 3'(i)]);
        end
        mag_or = mag[0] | mag[1] | mag[2];
        top    = '0;
        for (int b = 0; b < V_W; b++)
        begin
            if (mag_or[b])
            begin
                top = TB_W'(b);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (top > TB_W'(TOP_BIT))
            begin
                sh_tmp[i] = mag[i] >> (top - TB_W'(TOP_BIT));
            end
            else
            begin
                sh_tmp[i] = mag[i] << (TB_W'(TOP_BIT) - top);
            end
            s_new[i] = sh_tmp[i][S_W-1:0];
        end
    end

    assign sq_prod  = s_reg[cnt_reg[1:0]] * s_reg[cnt_reg[1:0]];
    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign num      = (N_W'(s_reg[comp_reg]) << (OUT_W - 2)) + N_W'(len_reg >> 1);
    assign r2       = {rem_reg, lo_reg[QB-1]};
    assign ge       = (r2 >= {1'b0, len_reg});
    assign q_fin    = {quo_reg[QB-2:0], ge};
    assign q_val    = neg_reg[comp_reg] ? -OUT_W'(q_fin) : OUT_W'(q_fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // In the done state the reload below decides the slot on its own.
            if (res_pop && res_valid_reg && state_reg != ST_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg != 5'd14)
                    begin
                        prod_reg <= mul_a * mul_b;
                    end
                    if (cnt_reg != 5'd0)
                    begin
                        if (!cnt_reg[0])
                        begin
                            if (prev_pair == 3'd0)
                            begin
                                det_reg <= diff;
                            end
                            else
                            begin
                                vec_reg[prev_pair - 3'd1] <= det_reg[V_W-1] ? -diff : diff;
                            end
                        end
                        else
                        begin
                            acc_reg <= prod_reg;
                        end
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd14)
                    begin
                        vsel_reg <= 1'b0;
                        if (det_reg == '0)
                        begin
                            status_reg <= STATUS_DET_ZERO;
                            for (int i = 0; i < 6; i++)
                            begin
                                out_reg[i] <= '0;
                            end
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (mag_or == '0)
                    begin
                        status_reg <= STATUS_LEN_ZERO;
                        for (int i = 0; i < 6; i++)
                        begin
                            out_reg[i] <= '0;
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            s_reg[i]   <= s_new[i];
                            neg_reg[i] <= vec_reg[vbase + 3'(i)][V_W-1];
                        end
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    sum_reg <= sum_reg + SUM_W'(sq_prod);
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd2)
                    begin
                        sq_n_reg   <= sum_reg + SUM_W'(sq_prod);
                        sq_res_reg <= '0;
                        sq_bit_reg <= SUM_W'(1) << (SUM_W - 2);
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        len_reg   <= sq_res_reg[L_W-1:0];
                        comp_reg  <= 2'd0;
                        state_reg <= ST_DIVLD;
                    end
                    else
                    begin
                        if (sq_n_reg >= sq_trial)
                        begin
                            sq_n_reg   <= sq_n_reg - sq_trial;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                ST_DIVLD:
                begin
                    rem_reg   <= L_W'(num >> QB);
                    lo_reg    <= num[QB-1:0];
                    quo_reg   <= '0;
                    cnt_reg   <= 5'(QB - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= ge ? L_W'(r2 - {1'b0, len_reg}) : L_W'(r2);
                    lo_reg  <= lo_reg << 1;
                    quo_reg <= q_fin;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        out_reg[vbase + 3'(comp_reg)] <= q_val;
                        if (comp_reg == 2'd2)
                        begin
                            if (!vsel_reg)
                            begin
                                vsel_reg  <= 1'b1;
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                status_reg <= STATUS_OK;
                                state_reg  <= ST_DONE;
                            end
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DIVLD;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_pop)
                    begin
                        res_reg.tangent_x  <= out_reg[0];
                        res_reg.tangent_y  <= out_reg[1];
                        res_reg.tangent_z  <= out_reg[2];
                        res_reg.binormal_x <= out_reg[3];
                        res_reg.binormal_y <= out_reg[4];
                        res_reg.binormal_z <= out_reg[5];
                        res_reg.status     <= status_reg;
                        res_valid_reg      <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/triangle_tangent_basis_core.sv
// Top level of the triangle tangent and binormal block.
//
//   Channel   Direction  Handshake           Payload
//   corner    in         push / full         one triangle corner (position, UV)
//   result    out        empty / pop         unit tangent, unit binormal, status
//
// A corner request is taken whenever the front end can hold it;
// the first two corners of a triangle never stall. The third corner turns into
// a job in a two-entry queue, and the back end's time per job is set by one
// shared multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle
// divider; a zero UV determinant ends a job right after the products.
// Reset clears the corner count, the queue and the result slot.
// A finished result waits in the output register while the front end keeps
// taking corners; the back end waits only when that register is still full.
`include "triangle_tangent_basis_core_assert.svh"

module triangle_tangent_basis_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ttb_pkg::corner_t corner,
    output logic             empty,
    input  logic             pop,
    output ttb_pkg::result_t result
);
    import ttb_pkg::*;

    job_t front_job;
    logic front_push;
    logic queue_full;
    job_t queue_job;
    logic queue_valid;
    logic back_take;
    logic res_valid;

    // Front end: collects corners and forms the deltas of each triangle.
    ttb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .corner     (corner),
        .full       (full),
        .job_push   (front_push),
        .job        (front_job),
        .queue_full (queue_full)
    );

    // Decoupling queue so the front end keeps taking corners during long math.
    ttb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_job),
        .full     (queue_full),
        .rd_en    (back_take),
        .rd_data  (queue_job),
        .rd_valid (queue_valid)
    );

    // Back end: products, normalization, output register.
    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_take  (back_take),
        .res       (result),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty = !res_valid;

    // A flagged result carries zero vectors.
    `TTB_ASSERT_IMPL(a_flag_zero, !empty && result.status != STATUS_OK, result.tangent_x == 0 && result.tangent_y == 0 && result.tangent_z == 0 && result.binormal_x == 0 && result.binormal_y == 0 && result.binormal_z == 0, "flagged result with nonzero vector")
    // Only defined status codes leave the block.
    `TTB_ASSERT_IMPL(a_status_code, !empty, result.status == STATUS_OK || result.status == STATUS_DET_ZERO || result.status == STATUS_LEN_ZERO, "undefined status code")
    // The x components of both unit vectors never exceed one.
    `TTB_ASSERT_IMPL(a_unit_range, !empty, result.tangent_x <= UNIT && result.tangent_x >= -UNIT && result.binormal_x <= UNIT && result.binormal_x >= -UNIT, "component out of unit range")

endmodule
